FILE: rtl/erq_pkg.sv
// erq_pkg: shared constants, types and command/status bundles for the extent request splitter
// no dependencies
package erq_pkg;

  localparam int MAX_EXTENTS_DEF = 64;
  localparam int RES_LIMIT       = 64;
  localparam int RES_W           = 7;
  localparam int BASE_SHIFT      = 10;
  localparam int LBA_SHIFT       = 9;   // 512 byte logical blocks
  localparam logic [15:0] UNINIT_MARK = 16'h8000;
  localparam logic [2:0]  LBS_RESET   = 3'd2;

  localparam int LOG_W  = 32;
  localparam int LEN_W  = 16;
  localparam int PHYS_W = 48;
  localparam int ENTRY_W = LOG_W + LEN_W + PHYS_W;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_SPLIT  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_PEND,
    EMIT_PEND_LAST,
    EMIT_PEND_BAD,
    EMIT_ZERO,
    EMIT_INCOMP
  } emit_t;

  typedef struct packed {
    logic  clear;
    logic  append;
    logic  start;
    logic  rd_en;
    logic  eval;
    logic  take;
    logic  skip;
    logic  set_short;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    len_zero;
    logic    more;
    logic    hit;
    logic    n_full;
    logic    pend_valid;
    logic    out_free;
    logic    incomplete;
    logic    short_room;
  } stat_t;

  typedef struct packed {
    logic [63:0] disk_byte_offset;
    logic [31:0] segment_length;
    logic [31:0] buffer_offset;
    logic [54:0] first_lba;
    logic [23:0] lba_count;
    logic        seg_is_read;
    logic        seg_status;
    logic        last;
  } seg_t;

endpackage

FILE: rtl/erq_in_if.sv
// erq_in_if: input channel of the extent request splitter
// depends on nothing
interface erq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] ext_logical_block;
  logic [15:0] ext_length;
  logic [47:0] ext_phys_block;
  logic [47:0] req_offset;
  logic [31:0] req_length;
  logic        is_read;

  modport source (output valid, action, ext_logical_block, ext_length, ext_phys_block,
                  req_offset, req_length, is_read, input ready);
  modport sink   (input valid, action, ext_logical_block, ext_length, ext_phys_block,
                  req_offset, req_length, is_read, output ready);
endinterface

FILE: rtl/erq_out_if.sv
// erq_out_if: result channel of the extent request splitter
// depends on nothing
interface erq_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] disk_byte_offset;
  logic [31:0] segment_length;
  logic [31:0] buffer_offset;
  logic [54:0] first_lba;
  logic [23:0] lba_count;
  logic        seg_is_read;
  logic        seg_status;
  logic        last;

  modport source (output valid, disk_byte_offset, segment_length, buffer_offset, first_lba,
                  lba_count, seg_is_read, seg_status, last, input ready);
  modport sink   (input valid, disk_byte_offset, segment_length, buffer_offset, first_lba,
                  lba_count, seg_is_read, seg_status, last, output ready);
endinterface

FILE: rtl/erq_ram.sv
// erq_ram: generic single write, single read ram with registered read data
// no dependencies
module erq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: rtl/erq_ctrl.sv
// erq_ctrl: sequencer for clear, append and the extent walk of a split
// depends on erq_pkg
module erq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  erq_pkg::stat_t st,
  output erq_pkg::cmd_t  cmd
);
  typedef enum logic [2:0] {S_IDLE, S_START, S_NEXT, S_RD, S_CALC, S_FIN, S_INC} state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    cmd.emit  = erq_pkg::EMIT_NONE;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (st.action)
            erq_pkg::ACT_CLEAR:  cmd.clear  = 1'b1;
            erq_pkg::ACT_APPEND: cmd.append = 1'b1;
            erq_pkg::ACT_SPLIT: begin
              cmd.start = 1'b1;
              state_nxt = S_START;
            end
            default: ;
          endcase
        end
      end
      S_START: begin
        if (!st.len_zero) begin
          state_nxt = S_NEXT;
        end else if (st.out_free) begin
          cmd.emit  = erq_pkg::EMIT_ZERO;
          state_nxt = S_IDLE;
        end
      end
      S_NEXT: begin
        if (st.more) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RD: begin
        cmd.eval  = 1'b1;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        if (!st.hit) begin
          cmd.skip  = 1'b1;
          state_nxt = S_NEXT;
        end else if (st.n_full) begin
          cmd.set_short = 1'b1;
          state_nxt     = S_FIN;
        end else if (!st.pend_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_NEXT;
        end else if (st.out_free) begin
          cmd.take  = 1'b1;
          cmd.emit  = erq_pkg::EMIT_PEND;
          state_nxt = S_NEXT;
        end
      end
      S_FIN: begin
        if (st.incomplete && !st.short_room && !st.n_full) begin
          if (!st.pend_valid) begin
            state_nxt = S_INC;
          end else if (st.out_free) begin
            cmd.emit  = erq_pkg::EMIT_PEND;
            state_nxt = S_INC;
          end
        end else if (st.out_free) begin
          cmd.emit  = (st.incomplete || st.short_room) ? erq_pkg::EMIT_PEND_BAD
                                                       : erq_pkg::EMIT_PEND_LAST;
          state_nxt = S_IDLE;
        end
      end
      S_INC: begin
        if (st.out_free) begin
          cmd.emit  = erq_pkg::EMIT_INCOMP;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

FILE: rtl/erq_dp.sv
// erq_dp: extent table, request registers, segment arithmetic and result register
// depends on erq_pkg and erq_ram
module erq_dp #(
  parameter int MAX_EXTENTS = erq_pkg::MAX_EXTENTS_DEF,
  localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1,
  localparam int CNT_W = $clog2(MAX_EXTENTS + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_wdata,
  input  logic [1:0]     in_action,
  input  logic [31:0]    in_logical,
  input  logic [15:0]    in_length,
  input  logic [47:0]    in_phys,
  input  logic [47:0]    in_offset,
  input  logic [31:0]    in_req_len,
  input  logic           in_is_read,
  input  logic           out_ready,
  output logic           out_valid,
  output erq_pkg::seg_t  out_seg,
  input  erq_pkg::cmd_t  cmd,
  output erq_pkg::stat_t st
);
  logic [2:0]       lbs_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] idx_r;
  logic [erq_pkg::RES_W-1:0] n_r;
  logic [31:0] len_r, done_r;
  logic [48:0] pos_r;
  logic        rd_r, short_r, pend_valid_r, out_valid_r;
  logic        hit_r;
  logic [31:0] io_r, delta_r;
  logic [47:0] phys_r;
  erq_pkg::seg_t pend_r, out_r;
  erq_pkg::seg_t out_nxt;

  logic [erq_pkg::ENTRY_W-1:0] rdata;
  logic                        full;
  logic [4:0]                  shamt;

  assign full  = (cnt_r == CNT_W'(MAX_EXTENTS));
  assign shamt = 5'(erq_pkg::BASE_SHIFT) + {2'b0, lbs_r};

  erq_ram #(.WIDTH(erq_pkg::ENTRY_W), .DEPTH(MAX_EXTENTS)) u_table (
    .clk   (clk),
    .we    (cmd.append && !full),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata ({in_logical, in_length, in_phys}),
    .re    (cmd.rd_en),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  // extent evaluation against the current file position
  logic [31:0] e_log;
  logic [15:0] e_len, e_blocks;
  logic [47:0] e_phys;
  logic [48:0] fstart;
  logic [32:0] span;
  logic [49:0] fend, avail;
  logic [31:0] rem, io;
  logic        hit;

  always_comb begin
    {e_log, e_len, e_phys} = rdata;
    e_blocks = (e_len > erq_pkg::UNINIT_MARK) ? (e_len - erq_pkg::UNINIT_MARK) : e_len;
    fstart   = {17'b0, e_log} << shamt;
    span     = {17'b0, e_blocks} << shamt;
    fend     = {1'b0, fstart} + {17'b0, span};
    hit      = (fstart <= pos_r) && (fend > {1'b0, pos_r});
    avail    = fend - {1'b0, pos_r};
    rem      = len_r - done_r;
    io       = (avail > {18'b0, rem}) ? rem : avail[31:0];
  end

  // segment formation
  logic [63:0] disk;
  logic [32:0] lsum;
  erq_pkg::seg_t seg_new;

  always_comb begin
    disk = ({16'b0, phys_r} << shamt) + {32'b0, delta_r};
    lsum = {24'b0, delta_r[erq_pkg::LBA_SHIFT-1:0]} + {1'b0, io_r} - 33'd1;
    seg_new.disk_byte_offset = disk;
    seg_new.segment_length   = io_r;
    seg_new.buffer_offset    = done_r;
    seg_new.first_lba        = disk[63:erq_pkg::LBA_SHIFT];
    seg_new.lba_count        = lsum[32:erq_pkg::LBA_SHIFT] + 24'd1;
    seg_new.seg_is_read      = rd_r;
    seg_new.seg_status       = 1'b0;
    seg_new.last             = 1'b0;
  end

  // next result register contents
  always_comb begin
    out_nxt = out_r;
    case (cmd.emit)
      erq_pkg::EMIT_PEND: out_nxt = pend_r;
      erq_pkg::EMIT_PEND_LAST: begin
        out_nxt      = pend_r;
        out_nxt.last = 1'b1;
      end
      erq_pkg::EMIT_PEND_BAD: begin
        out_nxt            = pend_r;
        out_nxt.seg_status = 1'b1;
        out_nxt.last       = 1'b1;
      end
      erq_pkg::EMIT_ZERO: begin
        out_nxt             = '0;
        out_nxt.seg_is_read = rd_r;
        out_nxt.last        = 1'b1;
      end
      erq_pkg::EMIT_INCOMP: begin
        out_nxt                = '0;
        out_nxt.segment_length = len_r - done_r;
        out_nxt.buffer_offset  = done_r;
        out_nxt.seg_is_read    = rd_r;
        out_nxt.seg_status     = 1'b1;
        out_nxt.last           = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lbs_r        <= erq_pkg::LBS_RESET;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      short_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        lbs_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        cnt_r <= '0;
      end else if (cmd.append && !full) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.start) begin
        short_r <= 1'b0;
      end else if (cmd.set_short) begin
        short_r <= 1'b1;
      end
      if (cmd.start) begin
        pend_valid_r <= 1'b0;
      end else if (cmd.take) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.emit == erq_pkg::EMIT_PEND || cmd.emit == erq_pkg::EMIT_PEND_LAST ||
                   cmd.emit == erq_pkg::EMIT_PEND_BAD) begin
        pend_valid_r <= 1'b0;
      end
      if (cmd.emit != erq_pkg::EMIT_NONE) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      len_r    <= in_req_len;
      rd_r     <= in_is_read;
      done_r   <= '0;
      pos_r    <= {1'b0, in_offset};
      idx_r    <= '0;
      n_r      <= '0;
    end
    if (cmd.eval) begin
      hit_r   <= hit;
      io_r    <= io;
      delta_r <= 32'(pos_r - fstart);
      phys_r  <= e_phys;
    end
    if (cmd.skip) begin
      idx_r <= idx_r + CNT_W'(1);
    end
    if (cmd.take) begin
      idx_r  <= idx_r + CNT_W'(1);
      n_r    <= n_r + erq_pkg::RES_W'(1);
      done_r <= done_r + io_r;
      pos_r  <= pos_r + {17'b0, io_r};
      pend_r <= seg_new;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_seg   = out_r;

  always_comb begin
    st.action     = erq_pkg::action_t'(in_action);
    st.len_zero   = (len_r == '0);
    st.more       = (idx_r < cnt_r) && (done_r < len_r);
    st.hit        = hit_r;
    st.n_full     = (n_r == erq_pkg::RES_W'(erq_pkg::RES_LIMIT));
    st.pend_valid = pend_valid_r;
    st.out_free   = !out_valid_r || out_ready;
    st.incomplete = (done_r < len_r);
    st.short_room = short_r;
  end
endmodule

FILE: rtl/extent_request_splitter.sv
// extent_request_splitter: top level, joins the walk controller and the datapath
// depends on erq_pkg, erq_in_if, erq_out_if, erq_ctrl, erq_dp, erq_ram
//
// clear and append beats are taken when idle; a split beat holds off new input
// until its walk and output beats end, output stalls included, with an extra
// incomplete beat when the request is not covered. each extent walked has a
// step to issue its table read, one to evaluate it and one to form the
// segment; the walk stops once the request is covered, the table is exhausted
// or the segment limit is reached; formed segments leave via the result register.
// synchronous active low reset empties the table and sets log_block_size to 2.
module extent_request_splitter #(
  parameter int MAX_EXTENTS = erq_pkg::MAX_EXTENTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [2:0] cfg_wdata,
  erq_in_if.sink    in_bus,
  erq_out_if.source out_bus
);
  erq_pkg::cmd_t  cmd;
  erq_pkg::stat_t st;
  erq_pkg::seg_t  seg;

  // controller decides what each beat does and paces the extent walk
  erq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath holds the table, the walk position and the result register
  erq_dp #(.MAX_EXTENTS(MAX_EXTENTS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_action  (in_bus.action),
    .in_logical (in_bus.ext_logical_block),
    .in_length  (in_bus.ext_length),
    .in_phys    (in_bus.ext_phys_block),
    .in_offset  (in_bus.req_offset),
    .in_req_len (in_bus.req_length),
    .in_is_read (in_bus.is_read),
    .out_ready  (out_bus.ready),
    .out_valid  (out_bus.valid),
    .out_seg    (seg),
    .cmd        (cmd),
    .st         (st)
  );

  // result beat fields straight from the output register
  assign out_bus.disk_byte_offset = seg.disk_byte_offset;
  assign out_bus.segment_length   = seg.segment_length;
  assign out_bus.buffer_offset    = seg.buffer_offset;
  assign out_bus.first_lba        = seg.first_lba;
  assign out_bus.lba_count        = seg.lba_count;
  assign out_bus.seg_is_read      = seg.seg_is_read;
  assign out_bus.seg_status       = seg.seg_status;
  assign out_bus.last             = seg.last;
endmodule
